// ===== hw/rtl/realized_volatility_bar_assert.svh =====
// Assertion macros for the RTL file realized_volatility_bar.sv of this block.
// RVB_ASSERT checks a property on every rising clock edge outside reset.
// RVB_NEVER checks that an expression is never true outside reset.
`ifndef REALIZED_VOLATILITY_BAR_ASSERT_SVH
`define REALIZED_VOLATILITY_BAR_ASSERT_SVH
`ifndef SYNTHESIS
`define RVB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RVB_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RVB_ASSERT(lbl, clk, rst_n, prop, msg)
`define RVB_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== hw/rtl/rvb_pkg.sv =====
`default_nettype none
package rvb_pkg;

  // Default fraction width of the log return and the result
  localparam int unsigned FRAC_BITS_DEF = 24;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned PRICE_W = 63;
  localparam int unsigned IDX_W   = 24;
  localparam int unsigned VOL_W   = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TRADE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BAR_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BAR_END   = 2'd2;

  // ln(2) in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [PRICE_W-1:0] price;
    logic [IDX_W-1:0]   bar_index;
  } rvb_in_t;

  typedef struct packed {
    logic [VOL_W-1:0] volatility;
    logic             valid_res;
  } rvb_out_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rvb_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rvb_div #(
  parameter int unsigned DW = 64,
  parameter int unsigned VW = rvb_pkg::IDX_W
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o
);
  localparam int unsigned CW = $clog2(DW);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;
  logic [DW-1:0] quo_q;

  logic [VW:0] rem_sh;
  logic [VW:0] rem_nx;
  logic        ge;

  // One shift-subtract step
  always_comb begin
    rem_sh = {rem_q, quo_q[DW-1]};
    ge     = (rem_sh >= {1'b0, dvs_q});
    rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= rem_nx[VW-1:0];
        quo_q <= {quo_q[DW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== hw/rtl/realized_volatility_bar.sv =====
`default_nettype none
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  in_data_i  (rvb_in_t)
// out       output     out_valid_o / out_ready_i out_data_o (rvb_out_t)
// cfg       input      cfg_we_i                 cfg_wdata_i (warm-up bar count)
//
// Trade and bar-start transfers are handled in the idle state. A bar end runs on one shared
// 32x32 multiplier and a bit-serial divider: two log2 runs, the return and sum update,
// two 64-bit divisions, the variance step, a 32-step square root and the write of the
// output register.
// in_ready_o is low from a bar end until its result is in the output register.
// The output register holds a result until taken; the input side keeps working.
// rst_ni clears all state asynchronously; no clearing pass is needed.
module realized_volatility_bar #(
  parameter int unsigned FRAC_BITS = rvb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire rvb_pkg::rvb_in_t         in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output rvb_pkg::rvb_out_t             out_data_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [rvb_pkg::IDX_W-1:0] cfg_wdata_i
);
  import rvb_pkg::*;

  `include "realized_volatility_bar_assert.svh"

  localparam int unsigned LOG_BITS = FRAC_BITS + 8;
  localparam int unsigned LW       = LOG_BITS + 6;
  localparam int unsigned RW       = FRAC_BITS + 8;
  localparam int unsigned CNTW     = $clog2(LOG_BITS + 32);

  localparam logic [65:0]   R_LIM = 66'd1 << (RW - 1);
  localparam logic [RW-1:0] R_HI  = {1'b0, {(RW-1){1'b1}}};
  localparam logic [RW-1:0] R_LO  = {1'b1, {(RW-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_LG_NORM, ST_LG_SQ, ST_DIFF, ST_LN_LO, ST_LN_HI, ST_LN_FIN, ST_SQ,
    ST_ACC, ST_CHECK, ST_DIV1, ST_DIV2, ST_MSQ, ST_VAR, ST_SQRT, ST_DONE
  } state_e;

  state_e st_q;

  // Architectural state
  logic               in_bar_q;
  logic [PRICE_W-1:0] bar_close_q;
  logic               has_bar_q;
  logic [PRICE_W-1:0] prev_close_q;
  logic               has_prev_q;
  logic [63:0]        sum_q;
  logic [63:0]        sumsq_q;
  logic [IDX_W-1:0]   warmup_q;

  // Working registers
  logic [IDX_W-1:0]    n_q;
  logic [CNTW-1:0]     cnt_q;
  logic [63:0]         nrm_q;
  logic [5:0]          exp_q;
  logic [31:0]         m_q;
  logic [LOG_BITS-1:0] frac_q;
  logic                which_q;
  logic [LW-1:0]       lga_q;
  logic [LW-1:0]       lgb_q;
  logic                neg_q;
  logic [63:0]         mag_q;
  logic [63:0]         mul_q;
  logic [31:0]         acc_q;
  logic [RW-1:0]       r_q;
  logic                sq_big_q;
  logic                res_valid_q;
  logic [63:0]         div_a_q;
  logic                div_start_q;
  logic [63:0]         mmag_q;
  logic [63:0]         msq_q;
  logic [63:0]         var_q;
  logic [32:0]         rem_q;
  logic [31:0]         root_q;
  logic                out_valid_q;
  rvb_out_t            out_data_q;

  // Divider
  logic        div_done;
  logic [63:0] div_quo;

  rvb_div #(
    .DW (64),
    .VW (IDX_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (div_a_q),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Shared multiplier operand select
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [RW-1:0] rmag;

  assign rmag = r_q[RW-1] ? (~r_q + 1'b1) : r_q;

  always_comb begin
    unique case (st_q)
      ST_LG_SQ: begin
        mul_a = m_q;
        mul_b = m_q;
      end
      ST_LN_LO: begin
        mul_a = mag_q[31:0];
        mul_b = LN2_Q32;
      end
      ST_LN_HI: begin
        mul_a = mag_q[63:32];
        mul_b = LN2_Q32;
      end
      ST_SQ: begin
        mul_a = 32'(rmag);
        mul_b = 32'(rmag);
      end
      ST_MSQ: begin
        mul_a = mmag_q[31:0];
        mul_b = mmag_q[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Normalize step: binary search for the leading one
  logic [6:0]  nrm_sh;
  logic        nrm_top0;
  logic [63:0] nrm_nx;
  logic [5:0]  exp_nx;

  always_comb begin
    nrm_sh   = 7'd32 >> cnt_q[2:0];
    nrm_top0 = ((nrm_q >> (7'd64 - nrm_sh)) == 64'd0);
    nrm_nx   = nrm_top0 ? (nrm_q << nrm_sh) : nrm_q;
    exp_nx   = nrm_top0 ? (exp_q - nrm_sh[5:0]) : exp_q;
  end

  // Squaring step of log2: one fraction bit per cycle
  logic          lg_bit;
  logic [LW-1:0] lg_val;

  assign lg_bit = mul_p[63];
  assign lg_val = {exp_q, frac_q[LOG_BITS-2:0], lg_bit};

  // Log2 difference magnitude
  logic [LW:0] d_raw;
  logic [LW:0] d_mag;

  assign d_raw = {1'b0, lga_q} - {1'b0, lgb_q};
  assign d_mag = d_raw[LW] ? (~d_raw + 1'b1) : d_raw;

  // Scale by ln2, round half up, saturate
  logic [65:0]   t_sum;
  logic [65:0]   t_rnd;
  logic [65:0]   t_cap;
  logic [RW-1:0] t_mag;

  always_comb begin
    t_sum = {2'b00, mul_q} + 66'(acc_q);
    t_rnd = (t_sum + 66'd128) >> 8;
    if (neg_q) begin
      t_cap = (t_rnd > R_LIM) ? R_LIM : t_rnd;
    end else begin
      t_cap = (t_rnd > (R_LIM - 66'd1)) ? (R_LIM - 66'd1) : t_rnd;
    end
    t_mag = t_cap[RW-1:0];
  end

  // Saturating accumulation
  logic [63:0] r64;
  logic [64:0] s65;
  logic [64:0] ss65;
  logic [63:0] sq_v;

  always_comb begin
    r64  = {{(64-RW){r_q[RW-1]}}, r_q};
    s65  = {sum_q[63], sum_q} + {r64[63], r64};
    sq_v = sq_big_q ? {64{1'b1}} : mul_q;
    ss65 = {1'b0, sumsq_q} + {1'b0, sq_v};
  end

  // Sum magnitude and variance
  logic [63:0] sum_mag;
  logic [63:0] var_nx;

  assign sum_mag = sum_q[63] ? (~sum_q + 1'b1) : sum_q;
  assign var_nx  = ((mmag_q[63:32] == 32'd0) && (msq_q > mul_q)) ? (msq_q - mul_q) : 64'd0;

  // Square root step: two radicand bits per cycle
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        rt_ge;
  logic [34:0] rem_sub;

  always_comb begin
    rem_sh  = {rem_q, var_q[63:62]};
    trial   = {1'b0, root_q, 2'b01};
    rt_ge   = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      in_bar_q     <= 1'b0;
      bar_close_q  <= '0;
      has_bar_q    <= 1'b0;
      prev_close_q <= '0;
      has_prev_q   <= 1'b0;
      sum_q        <= '0;
      sumsq_q      <= '0;
      warmup_q     <= '0;
      n_q          <= '0;
      cnt_q        <= '0;
      nrm_q        <= '0;
      exp_q        <= '0;
      m_q          <= '0;
      frac_q       <= '0;
      which_q      <= 1'b0;
      lga_q        <= '0;
      lgb_q        <= '0;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      mul_q        <= '0;
      acc_q        <= '0;
      r_q          <= '0;
      sq_big_q     <= 1'b0;
      res_valid_q  <= 1'b0;
      div_a_q      <= '0;
      div_start_q  <= 1'b0;
      mmag_q       <= '0;
      msq_q        <= '0;
      var_q        <= '0;
      rem_q        <= '0;
      root_q       <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      div_start_q <= 1'b0;
      if (cfg_we_i) begin
        warmup_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (in_data_i.command)
              CMD_TRADE: begin
                if (in_bar_q) begin
                  bar_close_q <= in_data_i.price;
                  has_bar_q   <= 1'b1;
                end
              end
              CMD_BAR_START: begin
                in_bar_q    <= 1'b1;
                bar_close_q <= '0;
                has_bar_q   <= 1'b0;
              end
              CMD_BAR_END: begin
                n_q <= in_data_i.bar_index;
                if (has_bar_q && has_prev_q) begin
                  priority if (bar_close_q == '0 && prev_close_q == '0) begin
                    r_q  <= '0;
                    st_q <= ST_SQ;
                  end else if (bar_close_q == '0) begin
                    r_q  <= R_LO;
                    st_q <= ST_SQ;
                  end else if (prev_close_q == '0) begin
                    r_q  <= R_HI;
                    st_q <= ST_SQ;
                  end else begin
                    nrm_q   <= {1'b0, bar_close_q};
                    exp_q   <= 6'd63;
                    cnt_q   <= '0;
                    which_q <= 1'b0;
                    st_q    <= ST_LG_NORM;
                  end
                end else begin
                  st_q <= ST_CHECK;
                end
              end
              default: begin
              end
            endcase
          end
        end

        ST_LG_NORM: begin
          nrm_q <= nrm_nx;
          exp_q <= exp_nx;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(5)) begin
            m_q   <= nrm_nx[63:32];
            cnt_q <= '0;
            st_q  <= ST_LG_SQ;
          end
        end

        ST_LG_SQ: begin
          m_q    <= lg_bit ? mul_p[63:32] : mul_p[62:31];
          frac_q <= {frac_q[LOG_BITS-2:0], lg_bit};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(LOG_BITS - 1)) begin
            cnt_q <= '0;
            if (!which_q) begin
              lga_q   <= lg_val;
              which_q <= 1'b1;
              nrm_q   <= {1'b0, prev_close_q};
              exp_q   <= 6'd63;
              st_q    <= ST_LG_NORM;
            end else begin
              lgb_q <= lg_val;
              st_q  <= ST_DIFF;
            end
          end
        end

        ST_DIFF: begin
          neg_q <= d_raw[LW];
          mag_q <= 64'(d_mag);
          st_q  <= ST_LN_LO;
        end

        ST_LN_LO: begin
          mul_q <= mul_p;
          st_q  <= ST_LN_HI;
        end

        ST_LN_HI: begin
          acc_q <= mul_q[63:32];
          mul_q <= mul_p;
          st_q  <= ST_LN_FIN;
        end

        ST_LN_FIN: begin
          r_q  <= neg_q ? (~t_mag + 1'b1) : t_mag;
          st_q <= ST_SQ;
        end

        ST_SQ: begin
          sq_big_q <= (64'(rmag) > 64'h0000_0000_FFFF_FFFF);
          mul_q    <= mul_p;
          st_q     <= ST_ACC;
        end

        ST_ACC: begin
          if (s65[64] != s65[63]) begin
            sum_q <= s65[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
          end else begin
            sum_q <= s65[63:0];
          end
          sumsq_q <= ss65[64] ? {64{1'b1}} : ss65[63:0];
          st_q    <= ST_CHECK;
        end

        ST_CHECK: begin
          res_valid_q <= (n_q >= warmup_q);
          root_q      <= '0;
          if ((n_q >= warmup_q) && (n_q != '0)) begin
            div_a_q     <= sum_mag;
            div_start_q <= 1'b1;
            st_q        <= ST_DIV1;
          end else begin
            st_q <= ST_DONE;
          end
        end

        ST_DIV1: begin
          if (div_done) begin
            mmag_q      <= div_quo;
            div_a_q     <= sumsq_q;
            div_start_q <= 1'b1;
            st_q        <= ST_DIV2;
          end
        end

        ST_DIV2: begin
          if (div_done) begin
            msq_q <= div_quo;
            st_q  <= ST_MSQ;
          end
        end

        ST_MSQ: begin
          mul_q <= mul_p;
          st_q  <= ST_VAR;
        end

        ST_VAR: begin
          var_q  <= var_nx;
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= '0;
          st_q   <= ST_SQRT;
        end

        ST_SQRT: begin
          rem_q  <= rt_ge ? rem_sub[32:0] : rem_sh[32:0];
          root_q <= {root_q[30:0], rt_ge};
          var_q  <= var_q << 2;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(31)) begin
            st_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q           <= 1'b1;
            out_data_q.volatility <= root_q;
            out_data_q.valid_res  <= res_valid_q;
            if (has_bar_q) begin
              prev_close_q <= bar_close_q;
              has_prev_q   <= 1'b1;
            end
            in_bar_q <= 1'b0;
            st_q     <= ST_IDLE;
          end
        end

        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A flagged result never carries a value
  `RVB_ASSERT(a_invalid_zero, clk_i, rst_ni, (st_q == ST_DONE && !res_valid_q) |-> (root_q == '0), "invalid result with nonzero value")
  // The sum of squares never shrinks on an update
  `RVB_ASSERT(a_sumsq_mono, clk_i, rst_ni, (st_q == ST_ACC) |=> (sumsq_q >= $past(sumsq_q)), "sum of squares decreased")
  // A pending result is not overwritten
  `RVB_ASSERT(a_no_overwrite, clk_i, rst_ni, (st_q == ST_DONE && out_valid_o && !out_ready_i) |=> (st_q == ST_DONE), "result overwritten")
  // Divider completions only arrive while waiting for them
  `RVB_ASSERT(a_div_done_state, clk_i, rst_ni, div_done |-> (st_q == ST_DIV1 || st_q == ST_DIV2), "unexpected divider completion")

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import rvb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 320;
  localparam longint RET_HI = (64'sd1 <<< 31) - 1;
  localparam longint RET_LO = -(64'sd1 <<< 31);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  rvb_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rvb_out_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_wdata = '0;

  realized_volatility_bar DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the block state
  logic [IDX_W-1:0]   mdl_warmup;
  logic               mdl_in_bar;
  logic [PRICE_W-1:0] mdl_close;
  logic               mdl_has_close;
  logic [PRICE_W-1:0] mdl_prev;
  logic               mdl_has_prev;
  longint             mdl_sum;
  logic [63:0]        mdl_sqsum;

  rvb_out_t vol_expected[$];
  int unsigned mismatches = 0;
  bit quiet = 1'b0;
  logic [PRICE_W-1:0] last_px = 63'd1000000;
  int unsigned bar_no = 0;

  // log2 in Q.32, x > 0
  function automatic logic [63:0] log2_q32(input logic [63:0] x);
    int p;
    logic [63:0] m;
    logic [63:0] r;
    p = 0;
    while (p < 63 && (x >> (p + 1)) != 0) p++;
    if (p >= 31) m = x >> (p - 31);
    else m = x << (31 - p);
    r = 64'(p) << 32;
    for (int i = 31; i >= 0; i--) begin
      m = m * m;
      if (m[63]) begin
        r[i] = 1'b1;
        m = m >> 32;
      end else begin
        m = m >> 31;
      end
    end
    return r;
  endfunction

  function automatic longint ln_ratio(input logic [63:0] cur, input logic [63:0] prv);
    longint d;
    longint v;
    logic [63:0] mag;
    logic [63:0] p_lo;
    logic [63:0] t;
    bit neg;
    if (cur == 0 && prv == 0) return 0;
    if (cur == 0) return RET_LO;
    if (prv == 0) return RET_HI;
    d = longint'(log2_q32(cur)) - longint'(log2_q32(prv));
    neg = d < 0;
    mag = neg ? 64'(-d) : 64'(d);
    p_lo = (mag & 64'hFFFF_FFFF) * 64'(LN2_Q32);
    t = (mag >> 32) * 64'(LN2_Q32) + (p_lo >> 32);
    t = (t + 64'd128) >> 8;
    if (t > 64'(RET_HI) + 1) t = 64'(RET_HI) + 1;
    v = neg ? -longint'(t) : longint'(t);
    if (v > RET_HI) v = RET_HI;
    if (v < RET_LO) v = RET_LO;
    return v;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Advance the mirror by one transfer; returns 1 when a result is due
  function automatic bit vol_predict(input rvb_in_t it, output rvb_out_t res);
    longint r;
    logic [63:0] mag;
    logic [63:0] sq;
    longint mean;
    logic [63:0] mmag;
    logic [63:0] msq;
    logic [63:0] var_v;
    logic [63:0] n;
    res = '0;
    if (it.command == CMD_TRADE) begin
      if (mdl_in_bar) begin
        mdl_close = it.price;
        mdl_has_close = 1'b1;
      end
      return 1'b0;
    end
    if (it.command == CMD_BAR_START) begin
      mdl_in_bar = 1'b1;
      mdl_close = '0;
      mdl_has_close = 1'b0;
      return 1'b0;
    end
    if (it.command != CMD_BAR_END) return 1'b0;
    if (mdl_has_close && mdl_has_prev) begin
      r = ln_ratio(64'(mdl_close), 64'(mdl_prev));
      mag = r < 0 ? 64'(-r) : 64'(r);
      sq = mag > 64'hFFFF_FFFF ? '1 : mag * mag;
      if (r > 0 && mdl_sum > 64'sh7FFF_FFFF_FFFF_FFFF - r) mdl_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
      else if (r < 0 && mdl_sum < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - r)
        mdl_sum = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
      else mdl_sum = mdl_sum + r;
      if (mdl_sqsum > ~sq) mdl_sqsum = '1;
      else mdl_sqsum = mdl_sqsum + sq;
    end
    n = 64'(it.bar_index);
    if (it.bar_index >= mdl_warmup) begin
      res.valid_res = 1'b1;
      if (n > 0) begin
        mean = mdl_sum / longint'(n);
        mmag = mean < 0 ? 64'(-(mean + 1)) + 1 : 64'(mean);
        msq = mdl_sqsum / n;
        var_v = 0;
        if (mmag <= 64'hFFFF_FFFF) begin
          var_v = msq > mmag * mmag ? msq - mmag * mmag : 0;
        end
        res.volatility = 32'(floor_sqrt(var_v));
      end
    end
    if (mdl_has_close) begin
      mdl_prev = mdl_close;
      mdl_has_prev = 1'b1;
    end
    mdl_in_bar = 1'b0;
    return 1'b1;
  endfunction

  // One input transfer; typed expectation overrides the prediction when given
  task automatic send_item(input rvb_in_t it, input bit typed, input rvb_out_t typed_res);
    rvb_out_t res;
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (vol_predict(it, res)) vol_expected.push_back(typed ? typed_res : res);
  endtask

  task automatic write_warmup(input logic [IDX_W-1:0] val);
    in_valid <= 1'b0;
    while (vol_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_warmup = val;
  endtask

  function automatic logic [PRICE_W-1:0] pick_price();
    logic [63:0] wide;
    case ($urandom_range(9))
      0: return '0;
      1: return PRICE_W'({$urandom, $urandom});
      2: begin
        wide = {$urandom, $urandom};
        return PRICE_W'(wide >> $urandom_range(62, 1));
      end
      default: begin
        if (last_px < 64) last_px = 63'd1000 + $urandom_range(100000);
        wide = 64'(last_px) + 64'($urandom_range(200)) - 64'd100;
        last_px = PRICE_W'(wide);
        return last_px;
      end
    endcase
  endfunction

  // Random command, unknown code included
  function automatic logic [CMD_W-1:0] CMD_CMD_NOISE();
    return CMD_W'($urandom_range(3));
  endfunction

  // Well-formed bars with random content, plus a share of noise
  task automatic random_phase(input int unsigned items);
    rvb_in_t it;
    int unsigned sent;
    int unsigned ntr;
    sent = 0;
    while (sent < items) begin
      quiet = (sent > items / 3) && (sent < items / 2);
      if ($urandom_range(99) < 12) begin
        it.command = CMD_CMD_NOISE();
        it.price = PRICE_W'({$urandom, $urandom});
        it.bar_index = IDX_W'($urandom);
        send_item(it, 1'b0, '0);
        sent++;
      end else begin
        it = '0;
        it.command = CMD_BAR_START;
        send_item(it, 1'b0, '0);
        ntr = $urandom_range(5);
        for (int k = 0; k < ntr; k++) begin
          it.command = CMD_TRADE;
          it.price = pick_price();
          send_item(it, 1'b0, '0);
        end
        it.command = CMD_BAR_END;
        bar_no++;
        it.bar_index = ($urandom_range(9) == 0) ? IDX_W'($urandom) : IDX_W'(bar_no);
        send_item(it, 1'b0, '0);
        sent += ntr + 2;
      end
    end
    quiet = 1'b0;
  endtask

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [PRICE_W-1:0] price;
    logic [IDX_W-1:0]   bar_index;
    logic               typed;
    logic [VOL_W-1:0]   vol;
    logic               ok;
  } row_t;

  localparam int unsigned NROWS = 22;
  localparam logic [PRICE_W-1:0] PMAX = '1;
  localparam logic [IDX_W-1:0] IMAX = '1;

  row_t dir_rows [NROWS] = '{
    // bar end straight after reset: index zero gives zero, valid
    '{CMD_BAR_END,   '0,      '0,   1'b1, 32'd0, 1'b1},
    '{CMD_TRADE,     63'd77,  '0,   1'b0, 32'd0, 1'b0},   // trade outside a bar
    '{CMD_BAR_START, '0,      '0,   1'b0, 32'd0, 1'b0},
    '{CMD_TRADE,     PMAX,    '0,   1'b0, 32'd0, 1'b0},
    '{CMD_BAR_END,   '0,      24'd1, 1'b0, 32'd0, 1'b0},
    '{CMD_BAR_START, '0,      '0,   1'b0, 32'd0, 1'b0},
    '{CMD_TRADE,     63'd1,   '0,   1'b0, 32'd0, 1'b0},
    '{CMD_BAR_END,   '0,      24'd2, 1'b0, 32'd0, 1'b0},   // huge drop
    '{CMD_BAR_START, '0,      '0,   1'b0, 32'd0, 1'b0},
    '{CMD_TRADE,     '0,      '0,   1'b0, 32'd0, 1'b0},
    '{CMD_BAR_END,   '0,      24'd3, 1'b0, 32'd0, 1'b0},   // zero close
    '{CMD_BAR_START, '0,      '0,   1'b0, 32'd0, 1'b0},
    '{CMD_TRADE,     63'd500, '0,   1'b0, 32'd0, 1'b0},
    '{CMD_BAR_END,   '0,      24'd4, 1'b0, 32'd0, 1'b0},   // zero previous
    '{CMD_BAR_START, '0,      '0,   1'b0, 32'd0, 1'b0},
    '{CMD_TRADE,     '0,      '0,   1'b0, 32'd0, 1'b0},
    '{CMD_BAR_END,   '0,      24'd5, 1'b0, 32'd0, 1'b0},   // previous nonzero again
    '{2'd3,          PMAX,    IMAX, 1'b0, 32'd0, 1'b0},   // unknown code
    '{CMD_BAR_END,   '0,      24'd6, 1'b0, 32'd0, 1'b0},   // end without start
    '{CMD_BAR_START, '0,      '0,   1'b0, 32'd0, 1'b0},
    '{CMD_BAR_END,   '0,      IMAX, 1'b0, 32'd0, 1'b0},   // bar with no trade
    '{CMD_BAR_END,   PMAX,    '0,   1'b1, 32'd0, 1'b1}
  };

  // Result checking
  always @(posedge clk) begin
    rvb_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (vol_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result vol=%h valid=%b",
                                       out_data.volatility, out_data.valid_res);
      end else begin
        exp_r = vol_expected.pop_front();
        if (out_data.volatility !== exp_r.volatility ||
            out_data.valid_res !== exp_r.valid_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected vol=%h valid=%b, got vol=%h valid=%b",
                     exp_r.volatility, exp_r.valid_res,
                     out_data.volatility, out_data.valid_res);
        end
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 25);
  end

  initial begin
    #20_000_000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rvb_in_t it;
    rvb_out_t tr;
    mdl_warmup = '0;
    mdl_in_bar = 1'b0;
    mdl_close = '0;
    mdl_has_close = 1'b0;
    mdl_prev = '0;
    mdl_has_prev = 1'b0;
    mdl_sum = 0;
    mdl_sqsum = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[i]) begin
      it.command = dir_rows[i].command;
      it.price = dir_rows[i].price;
      it.bar_index = dir_rows[i].bar_index;
      tr.volatility = dir_rows[i].vol;
      tr.valid_res = dir_rows[i].ok;
      send_item(it, dir_rows[i].typed, tr);
    end

    // Random phases over warm-up settings, extremes included
    write_warmup('0);
    random_phase(300);
    write_warmup(IMAX);
    random_phase(250);
    write_warmup(IDX_W'($urandom_range(40)));
    random_phase(300);
    write_warmup(IDX_W'($urandom_range(IMAX)));
    random_phase(80);
    write_warmup(24'd5);
    random_phase(200);

    in_valid <= 1'b0;
    while (vol_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
